[src/dns_reply_a_record_extractor_assert.svh]
// ----------------------------------------------------------------------------
// dns reply a-record extractor assertion macros
// shared concurrent check forms for the extractor modules
// ----------------------------------------------------------------------------
`ifndef DNS_REPLY_A_RECORD_EXTRACTOR_ASSERT_SVH
`define DNS_REPLY_A_RECORD_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define DNSRAE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnsrae check failed");

// next-cycle implication
`define DNSRAE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnsrae check failed");

`endif

[src/dnsrae_pkg.sv]
// ----------------------------------------------------------------------------
// dnsrae_pkg
// types and constants shared by the dns reply a-record extractor
// ----------------------------------------------------------------------------
package dnsrae_pkg;

    localparam int MAX_FOUND      = 16;
    localparam int PACKET_BYTES   = 1500;
    localparam int HEADER_BYTES   = 12;
    localparam int QFIXED_BYTES   = 4;
    localparam int RR_FIXED_BYTES = 10;
    localparam int RCODE_NXDOMAIN = 3;
    localparam logic [7:0] PTR_MARK = 8'hC0;

    // header byte positions
    localparam int OFS_ID_HI      = 0;
    localparam int OFS_ID_LO      = 1;
    localparam int OFS_FLAGS_LO   = 3;
    localparam int OFS_ANCOUNT_HI = 6;
    localparam int OFS_ANCOUNT_LO = 7;

    // answer record fixed-part positions
    localparam int FX_TYPE_HI = 0;
    localparam int FX_TYPE_LO = 1;
    localparam int FX_LEN_HI  = 8;
    localparam int FX_LEN_LO  = 9;

    localparam int OFFSET_W = $clog2(PACKET_BYTES + 1);
    localparam int FOUND_W  = $clog2(MAX_FOUND + 1);
    localparam int COUNT_W  = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QSKIP,
        PH_QPTR,
        PH_QFIXED,
        PH_ANAME,
        PH_ASKIP,
        PH_APTR,
        PH_AFIXED,
        PH_ADATA,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NXDOMAIN,
        ST_SERVFAIL,
        ST_BAD_QUESTION,
        ST_SHORT,
        ST_ID_MISMATCH
    } status_t;

    typedef enum logic {
        KIND_ADDRESS,
        KIND_STATUS
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [31:0]         ipv4_address;
        status_t             status;
        logic [COUNT_W-1:0]  address_count;
        logic                end_of_run;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic                addr_push;
        logic                stat_push;
        logic [31:0]         addr;
        status_t             status;
        logic [FOUND_W-1:0]  count;
    } push_t;

endpackage

[src/dnsrae_in_if.sv]
// ----------------------------------------------------------------------------
// dnsrae_in_if
// packet byte channel: one reply byte per transaction
// ----------------------------------------------------------------------------
interface dnsrae_in_if;

    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] query_id;

    modport source (output valid, output data_byte, output last_byte, output query_id,
                    input ready);
    modport sink (input valid, input data_byte, input last_byte, input query_id,
                  output ready);

endinterface

[src/dnsrae_out_if.sv]
// ----------------------------------------------------------------------------
// dnsrae_out_if
// result channel: an address or an end-of-packet status per transaction
// ----------------------------------------------------------------------------
interface dnsrae_out_if;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] ipv4_address;
    logic [2:0]  status;
    logic [4:0]  address_count;
    logic        end_of_run;

    modport source (output valid, output kind, output ipv4_address, output status,
                    output address_count, output end_of_run, input ready);
    modport sink (input valid, input kind, input ipv4_address, input status,
                  input address_count, input end_of_run, output ready);

endinterface

[src/dnsrae_parser.sv]
// ----------------------------------------------------------------------------
// dnsrae_parser
// per-byte parse state: header check, name skipping, answer walk
// ----------------------------------------------------------------------------
`include "dns_reply_a_record_extractor_assert.svh"

module dnsrae_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [15:0]        query_id,
    output dnsrae_pkg::push_t  push
);
    import dnsrae_pkg::*;

    phase_t              phase_reg,     phase_next;
    logic [OFFSET_W-1:0] offset_reg,    offset_next;
    logic                id_match_reg,  id_match_next;
    logic [3:0]          rcode_reg,     rcode_next;
    logic [15:0]         an_total_reg,  an_total_next;
    logic [15:0]         an_seen_reg,   an_seen_next;
    logic [7:0]          label_rem_reg, label_rem_next;
    logic [3:0]          fixed_idx_reg, fixed_idx_next;
    logic [15:0]         rr_type_reg,   rr_type_next;
    logic [15:0]         rr_len_reg,    rr_len_next;
    logic [31:0]         shift_reg,     shift_next;
    logic [FOUND_W-1:0]  found_reg,     found_next;
    logic [7:0]          id_low_reg,    id_low_next;
    logic                is_addr_reg,   is_addr_next;

    logic                addr_hit;
    status_t             status_val;
    logic [3:0]          fixed_inc;

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        id_match_next  = id_match_reg;
        rcode_next     = rcode_reg;
        an_total_next  = an_total_reg;
        an_seen_next   = an_seen_reg;
        label_rem_next = label_rem_reg;
        fixed_idx_next = fixed_idx_reg;
        rr_type_next   = rr_type_reg;
        rr_len_next    = rr_len_reg;
        shift_next     = shift_reg;
        found_next     = found_reg;
        id_low_next    = id_low_reg;
        is_addr_next   = is_addr_reg;
        addr_hit       = 1'b0;
        status_val     = ST_OK;
        fixed_inc      = fixed_idx_reg + 4'd1;

        // bytes beyond the packet limit are dropped but last_byte still counts
        if (offset_reg < OFFSET_W'(PACKET_BYTES))
        begin
            offset_next = offset_reg + OFFSET_W'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == OFFSET_W'(OFS_ID_HI))
                    begin
                        id_match_next = (data_byte == query_id[15:8]);
                        id_low_next   = query_id[7:0];
                    end
                    else if (offset_reg == OFFSET_W'(OFS_ID_LO))
                    begin
                        if (data_byte != id_low_reg)
                        begin
                            id_match_next = 1'b0;
                        end
                    end
                    else if (offset_reg == OFFSET_W'(OFS_FLAGS_LO))
                    begin
                        rcode_next = data_byte[3:0];
                    end
                    else if (offset_reg == OFFSET_W'(OFS_ANCOUNT_HI))
                    begin
                        an_total_next = {data_byte, 8'h00};
                    end
                    else if (offset_reg == OFFSET_W'(OFS_ANCOUNT_LO))
                    begin
                        an_total_next = {an_total_reg[15:8], data_byte};
                    end
                    else if (offset_reg == OFFSET_W'(HEADER_BYTES - 1))
                    begin
                        phase_next = (id_match_reg && rcode_reg == 4'd0) ? PH_QNAME : PH_DONE;
                    end
                end
                PH_QNAME, PH_ANAME:
                begin
                    if (data_byte == 8'h00)
                    begin
                        phase_next     = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                        fixed_idx_next = 4'd0;
                    end
                    else if ((data_byte & PTR_MARK) == PTR_MARK)
                    begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                    end
                    else
                    begin
                        label_rem_next = data_byte;
                        phase_next     = (phase_reg == PH_QNAME) ? PH_QSKIP : PH_ASKIP;
                    end
                end
                PH_QSKIP, PH_ASKIP:
                begin
                    label_rem_next = label_rem_reg - 8'd1;
                    if (label_rem_next == 8'd0)
                    begin
                        phase_next = (phase_reg == PH_QSKIP) ? PH_QNAME : PH_ANAME;
                    end
                end
                PH_QPTR, PH_APTR:
                begin
                    // second pointer byte ends the name
                    phase_next     = (phase_reg == PH_QPTR) ? PH_QFIXED : PH_AFIXED;
                    fixed_idx_next = 4'd0;
                end
                PH_QFIXED:
                begin
                    fixed_idx_next = fixed_inc;
                    if (fixed_inc >= 4'(QFIXED_BYTES))
                    begin
                        phase_next = (an_seen_reg < an_total_reg) ? PH_ANAME : PH_DONE;
                    end
                end
                PH_AFIXED:
                begin
                    if (fixed_idx_reg == 4'(FX_TYPE_HI))
                    begin
                        rr_type_next = {data_byte, 8'h00};
                    end
                    else if (fixed_idx_reg == 4'(FX_TYPE_LO))
                    begin
                        rr_type_next = {rr_type_reg[15:8], data_byte};
                    end
                    else if (fixed_idx_reg == 4'(FX_LEN_HI))
                    begin
                        rr_len_next = {data_byte, 8'h00};
                    end
                    else if (fixed_idx_reg == 4'(FX_LEN_LO))
                    begin
                        rr_len_next = {rr_len_reg[15:8], data_byte};
                    end
                    fixed_idx_next = fixed_inc;
                    if (fixed_inc >= 4'(RR_FIXED_BYTES))
                    begin
                        fixed_idx_next = 4'd0;
                        shift_next     = 32'd0;
                        is_addr_next   = (rr_type_next == 16'd1) && (rr_len_next == 16'd4);
                        if (rr_len_next == 16'd0)
                        begin
                            an_seen_next = an_seen_reg + 16'd1;
                            phase_next   = (an_seen_next < an_total_reg) ? PH_ANAME : PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_ADATA;
                        end
                    end
                end
                PH_ADATA:
                begin
                    shift_next  = {data_byte, shift_reg[31:8]};
                    rr_len_next = rr_len_reg - 16'd1;
                    if (rr_len_next == 16'd0)
                    begin
                        if (is_addr_reg && found_reg < FOUND_W'(MAX_FOUND))
                        begin
                            found_next = found_reg + FOUND_W'(1);
                            addr_hit   = 1'b1;
                        end
                        an_seen_next = an_seen_reg + 16'd1;
                        phase_next   = (an_seen_next < an_total_reg) ? PH_ANAME : PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (offset_next < OFFSET_W'(HEADER_BYTES))
        begin
            status_val = ST_SHORT;
        end
        else if (!id_match_next)
        begin
            status_val = ST_ID_MISMATCH;
        end
        else if (rcode_next == 4'(RCODE_NXDOMAIN))
        begin
            status_val = ST_NXDOMAIN;
        end
        else if (rcode_next != 4'd0)
        begin
            status_val = ST_SERVFAIL;
        end
        else if (phase_next inside {PH_QNAME, PH_QSKIP, PH_QPTR})
        begin
            status_val = ST_BAD_QUESTION;
        end

        push.addr_push = accept && addr_hit;
        push.stat_push = accept && last_byte;
        push.addr      = shift_next;
        push.status    = status_val;
        push.count     = found_next;

        // packet end: all per-packet state back to its start values
        if (last_byte)
        begin
            phase_next     = PH_HEADER;
            offset_next    = '0;
            id_match_next  = 1'b1;
            rcode_next     = 4'd0;
            an_total_next  = 16'd0;
            an_seen_next   = 16'd0;
            label_rem_next = 8'd0;
            fixed_idx_next = 4'd0;
            rr_type_next   = 16'd0;
            rr_len_next    = 16'd0;
            shift_next     = 32'd0;
            found_next     = '0;
            id_low_next    = 8'd0;
            is_addr_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= '0;
            id_match_reg  <= 1'b1;
            rcode_reg     <= 4'd0;
            an_total_reg  <= 16'd0;
            an_seen_reg   <= 16'd0;
            label_rem_reg <= 8'd0;
            fixed_idx_reg <= 4'd0;
            rr_type_reg   <= 16'd0;
            rr_len_reg    <= 16'd0;
            shift_reg     <= 32'd0;
            found_reg     <= '0;
            id_low_reg    <= 8'd0;
            is_addr_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            id_match_reg  <= id_match_next;
            rcode_reg     <= rcode_next;
            an_total_reg  <= an_total_next;
            an_seen_reg   <= an_seen_next;
            label_rem_reg <= label_rem_next;
            fixed_idx_reg <= fixed_idx_next;
            rr_type_reg   <= rr_type_next;
            rr_len_reg    <= rr_len_next;
            shift_reg     <= shift_next;
            found_reg     <= found_next;
            id_low_reg    <= id_low_next;
            is_addr_reg   <= is_addr_next;
        end
    end

    `DNSRAE_ASSERT_NOW(a_addr_from_data, clk, rst_n, push.addr_push, phase_reg == PH_ADATA && is_addr_reg)
    `DNSRAE_ASSERT_NOW(a_found_cap, clk, rst_n, 1'b1, found_reg <= FOUND_W'(MAX_FOUND))
    `DNSRAE_ASSERT_NEXT(a_clear_on_last, clk, rst_n, push.stat_push, offset_reg == '0 && found_reg == '0 && phase_reg == PH_HEADER)

endmodule

[src/dnsrae_out_fifo.sv]
// ----------------------------------------------------------------------------
// dnsrae_out_fifo
// result register queue: takes up to two results a cycle and, while res.ready is high, gives one
// ----------------------------------------------------------------------------
`include "dns_reply_a_record_extractor_assert.svh"

module dnsrae_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  dnsrae_pkg::push_t push,
    output logic              room,
    dnsrae_out_if.source      res
);
    import dnsrae_pkg::*;

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg,  count_next;
    logic [FIFO_PTR_W-1:0]  stat_slot;
    logic [FIFO_CNT_W-1:0]  push_n;
    logic                   pop;
    result_t                addr_entry;
    result_t                stat_entry;
    result_t                head;

    always_comb
    begin
        addr_entry.kind          = KIND_ADDRESS;
        addr_entry.ipv4_address  = push.addr;
        addr_entry.status        = ST_OK;
        addr_entry.address_count = '0;
        addr_entry.end_of_run    = 1'b0;

        stat_entry.kind          = KIND_STATUS;
        stat_entry.ipv4_address  = 32'd0;
        stat_entry.status        = push.status;
        stat_entry.address_count = COUNT_W'(push.count);
        stat_entry.end_of_run    = 1'b1;
    end

    // address goes ahead of the status when both come from one byte
    assign stat_slot   = push.addr_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
    assign push_n      = FIFO_CNT_W'(push.addr_push) + FIFO_CNT_W'(push.stat_push);
    assign pop         = res.valid && res.ready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + push_n - FIFO_CNT_W'(pop);
    assign room        = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.addr_push)
        begin
            entry_reg[wr_ptr_reg] <= addr_entry;
        end
        if (push.stat_push)
        begin
            entry_reg[stat_slot] <= stat_entry;
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign res.valid         = count_reg != '0;
    assign res.kind          = head.kind;
    assign res.ipv4_address  = head.ipv4_address;
    assign res.status        = head.status;
    assign res.address_count = head.address_count;
    assign res.end_of_run    = head.end_of_run;

    `DNSRAE_ASSERT_NOW(a_push_has_room, clk, rst_n, push.addr_push || push.stat_push, count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    `DNSRAE_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `DNSRAE_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && !push.addr_push && !push.stat_push, count_reg == $past(count_reg) - FIFO_CNT_W'(1))

endmodule

[src/dns_reply_a_record_extractor.sv]
// ----------------------------------------------------------------------------
// dns_reply_a_record_extractor
// streams a dns reply byte by byte and returns its a-record addresses
// followed by an end-of-packet status
// ----------------------------------------------------------------------------
//  channel  dir  payload                                                 per transaction
//  pkt      in   data_byte, last_byte, query_id                          one reply byte
//  res      out  kind, ipv4_address, status, address_count, end_of_run   one result
//
//  one byte per cycle while the queue has room; each byte is parsed in the cycle it is taken
//  a result is in the queue from the cycle after the byte that caused it
//  a final byte that also completes an address gives two results, drained
//  one per cycle while res.ready is high from a four-entry result queue
//  pkt.ready drops only while the queue holds more than two results
//  reset is asynchronous and leaves the parser at the start of a packet
// ----------------------------------------------------------------------------
module dns_reply_a_record_extractor
(
    input  logic          clk,
    input  logic          rst_n,
    dnsrae_in_if.sink     pkt,
    dnsrae_out_if.source  res
);
    import dnsrae_pkg::*;

    push_t push;
    logic  room;
    logic  accept;

    assign pkt.ready = room;
    assign accept    = pkt.valid && room;

    dnsrae_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (pkt.data_byte),
        .last_byte (pkt.last_byte),
        .query_id  (pkt.query_id),
        .push      (push)
    );

    dnsrae_out_fifo u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

endmodule
